/* rtl/tch_pkg.sv */
// ----------------------------------------------------------------------------
// tch_pkg: shared types and constants for the tilt-compensated heading block
// Holds the CORDIC angle table, register indexes and the lane result type.
// ----------------------------------------------------------------------------
package tch_pkg;

  localparam int unsigned AngTabLen = 24;

  typedef enum logic [0:0] {
    REG_LEAK_KEEP = 1'b0,
    REG_LEAK_TAKE = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic signed [31:0] offset;
    logic signed [16:0] field;
  } lane_res_t;

  function automatic logic [31:0] atan_of(input logic [4:0] i);
    logic [31:0] v;
    begin
      unique case (i)
        5'd0:  v = 32'd536870912;
        5'd1:  v = 32'd316933406;
        5'd2:  v = 32'd167458907;
        5'd3:  v = 32'd85004756;
        5'd4:  v = 32'd42667331;
        5'd5:  v = 32'd21354465;
        5'd6:  v = 32'd10679838;
        5'd7:  v = 32'd5340245;
        5'd8:  v = 32'd2670163;
        5'd9:  v = 32'd1335087;
        5'd10: v = 32'd667544;
        5'd11: v = 32'd333772;
        5'd12: v = 32'd166886;
        5'd13: v = 32'd83443;
        5'd14: v = 32'd41722;
        5'd15: v = 32'd20861;
        5'd16: v = 32'd10430;
        5'd17: v = 32'd5215;
        5'd18: v = 32'd2608;
        5'd19: v = 32'd1304;
        5'd20: v = 32'd652;
        5'd21: v = 32'd326;
        5'd22: v = 32'd163;
        5'd23: v = 32'd81;
        default: v = 32'd0;
      endcase
      return v;
    end
  endfunction

endpackage

/* rtl/tilt_compensated_heading.sv */
// ----------------------------------------------------------------------------
// tilt_compensated_heading: tilt-compensated compass heading
// Hard-iron tracking in three lanes, tilt projection and CORDIC atan2.
// ----------------------------------------------------------------------------
// One word is taken at a time. The three axis lanes update their hard-iron
// offsets at the accepting edge. The tilt projection then runs its steps in
// order (coefficients, field times coefficient products, sums, CORDIC load),
// the iterative CORDIC runs its micro-rotations and then scales the angle to
// 1/64 degree, and the block then moves into its output state. The result
// stays in the output register until taken; a new word is accepted at the
// earliest in the cycle after the result leaves. Configuration writes are
// always ready and take effect on the next word.
module tilt_compensated_heading
  import tch_pkg::*;
#(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // mag_x[15:0], mag_y[31:16], mag_z[47:32], grav_x[63:48], grav_y[79:64],
  // grav_z[95:80]
  input  logic [95:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // field_x[16:0], field_y[33:17], field_z[50:34], heading[65:51], zero fill
  output logic [71:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LANE = 5'b00010,
    S_PROJ = 5'b00100,
    S_CORD = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic [15:0] keep_r, take_r;
  logic [2:0]  pc_r, pc_nxt;
  logic signed [15:0] gx_r, gy_r, gz_r;
  logic signed [15:0] mag [3];
  lane_res_t   lres [3];
  logic signed [31:0] cxx_r, cxy_r, cxz_r, cyy_r, cyz_r;
  logic signed [48:0] t_r [6];
  logic signed [63:0] xh_r, yh_r;
  logic        cstart, cdone;
  logic [14:0] hd;
  logic        acc;

  assign acc       = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign mag[0]    = in_tdata[15:0];
  assign mag[1]    = in_tdata[31:16];
  assign mag[2]    = in_tdata[47:32];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_r <= 16'd65208;
      take_r <= 16'd328;
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_LEAK_KEEP: keep_r <= cfg_data;
        REG_LEAK_TAKE: take_r <= cfg_data;
        default: ;
      endcase
    end
  end

  genvar a;
  generate
    for (a = 0; a < 3; a++) begin : g_lane
      tch_lane u_lane (
        .clk(clk), .rst_n(rst_n), .upd(acc), .keep(keep_r), .take(take_r),
        .sample(mag[a]), .res(lres[a])
      );
    end
  endgenerate

  // Projection sequence, one multiply rank per cycle.
  always_ff @(posedge clk) begin
    if (acc) begin
      gx_r <= in_tdata[63:48];
      gy_r <= in_tdata[79:64];
      gz_r <= in_tdata[95:80];
    end
    if (state_r == S_LANE) begin
      cxx_r <= 32'sd268435456 - gx_r * gx_r;
      cxy_r <= gx_r * gy_r;
      cxz_r <= gx_r * gz_r;
      cyy_r <= 32'sd268435456 - gy_r * gy_r;
      cyz_r <= gy_r * gz_r;
    end
    if (state_r == S_PROJ && pc_r == 3'd0) begin
      t_r[0] <= lres[0].field * cxx_r;
      t_r[1] <= lres[1].field * cxy_r;
      t_r[2] <= lres[2].field * cxz_r;
      t_r[3] <= lres[0].field * cxy_r;
      t_r[4] <= lres[1].field * cyy_r;
      t_r[5] <= lres[2].field * cyz_r;
    end
    if (state_r == S_PROJ && pc_r == 3'd1) begin
      xh_r <= 64'(t_r[0]) - 64'(t_r[1]) - 64'(t_r[2]);
      yh_r <= 64'(t_r[4]) - 64'(t_r[3]) - 64'(t_r[5]);
    end
  end

  assign cstart = (state_r == S_PROJ) && (pc_r == 3'd2);

  tch_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst_n(rst_n), .start(cstart), .xin(xh_r), .yin(yh_r),
    .done(cdone), .heading(hd)
  );

  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    unique case (state_r)
      S_IDLE: if (acc) state_nxt = S_LANE;
      S_LANE: begin
        state_nxt = S_PROJ;
        pc_nxt    = '0;
      end
      S_PROJ: begin
        pc_nxt = pc_r + 3'd1;
        if (pc_r == 3'd2) state_nxt = S_CORD;
      end
      S_CORD: if (cdone) state_nxt = S_OUT;
      S_OUT:  if (out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pc_r    <= '0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
    end
  end

  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = {6'd0, hd, lres[2].field, lres[1].field, lres[0].field};

endmodule

/* rtl/tch_lane.sv */
// ----------------------------------------------------------------------------
// tch_lane: one axis of hard-iron tracking
// Updates the leaky offset of its axis and produces the corrected field.
// ----------------------------------------------------------------------------
module tch_lane
  import tch_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               upd,
  input  logic [15:0]        keep,
  input  logic [15:0]        take,
  input  logic signed [15:0] sample,
  output lane_res_t          res
);

  logic signed [31:0] off_r, off_nxt;
  logic signed [16:0] fld_r, fld_nxt;
  logic signed [48:0] p_keep;
  logic signed [32:0] p_take;
  logic signed [49:0] acc;
  logic signed [33:0] rnd;
  logic signed [33:0] diff;
  logic signed [17:0] fl;

  // Two products, about 32x16 and 16x16; the add and round follow in the same cycle.
  always_comb begin
    p_keep  = off_r * $signed({1'b0, keep});
    p_take  = sample * $signed({1'b0, take});
    acc     = 50'(p_keep) + (50'(p_take) <<< 16) + 50'sd32768;
    rnd     = acc[49:16];
    if (rnd > 34'sh07FFFFFFF)       off_nxt = 32'sh7FFFFFFF;
    else if (rnd < -34'sh080000000) off_nxt = 32'sh80000000;
    else                            off_nxt = rnd[31:0];
    diff    = ({{2{sample[15]}}, sample, 16'd0}) - 34'(off_nxt);
    fl      = diff[33:16];
    if (fl > 18'sd65535)        fld_nxt = 17'sd65535;
    else if (fl < -18'sd65536)  fld_nxt = -17'sd65536;
    else                        fld_nxt = fl[16:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r <= '0;
    end else if (upd) begin
      off_r <= off_nxt;
    end
    if (upd) begin
      fld_r <= fld_nxt;
    end
  end

  assign res.offset = off_r;
  assign res.field  = fld_r;

endmodule

/* rtl/tch_cordic.sv */
// ----------------------------------------------------------------------------
// tch_cordic: iterative vectoring CORDIC
// One micro-rotation a cycle; yields the heading in 1/64 degree.
// ----------------------------------------------------------------------------
module tch_cordic
  import tch_pkg::*;
#(
  parameter int unsigned STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [63:0] xin,
  input  logic signed [63:0] yin,
  output logic               done,
  output logic [14:0]        heading
);

  localparam int unsigned NStep = (STEPS < AngTabLen) ? STEPS : AngTabLen;

  logic signed [65:0] x_r, y_r;
  logic [31:0]        ang_r;
  logic [4:0]         i_r;
  logic               busy_r, zero_r, done_r;
  logic signed [65:0] xs, ys;
  logic [63:0]        prod;
  logic [14:0]        hd_r;
  logic [31:0]        hraw;

  assign xs   = x_r >>> i_r;
  assign ys   = y_r >>> i_r;
  assign prod = {32'd0, ang_r} * 64'd23040 + 64'h80000000;
  assign hraw = prod[63:32];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        zero_r <= (xin == 64'sd0) && (yin == 64'sd0);
        i_r    <= '0;
        if (xin < 0) begin
          x_r   <= -66'(xin);
          y_r   <= -66'(yin);
          ang_r <= 32'h80000000;
        end else begin
          x_r   <= 66'(xin);
          y_r   <= 66'(yin);
          ang_r <= '0;
        end
      end else if (busy_r) begin
        if (i_r == 5'(NStep)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          if (zero_r)                 hd_r <= '0;
          else if (hraw >= 32'd23040) hd_r <= 15'(hraw - 32'd23040);
          else                        hd_r <= hraw[14:0];
        end else begin
          i_r <= i_r + 5'd1;
          if (!y_r[65]) begin
            x_r   <= x_r + ys;
            y_r   <= y_r - xs;
            ang_r <= ang_r + atan_of(i_r);
          end else begin
            x_r   <= x_r - ys;
            y_r   <= y_r + xs;
            ang_r <= ang_r - atan_of(i_r);
          end
        end
      end
    end
  end

  assign done    = done_r;
  assign heading = hd_r;

endmodule

/* rtl/tch_checker.sv */
// ----------------------------------------------------------------------------
// tch_checker: port-level checks for the heading block
// Watches handshakes and the output range.
// ----------------------------------------------------------------------------
module tch_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata
);

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[65:51] < 15'd23040)) else $error("heading range");

  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid)) else $error("input ready while result pending");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped");

  a_nonew: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready) else $error("second word taken");

endmodule

bind tilt_compensated_heading tch_checker u_tch_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);
